@@ hdl/sdspi_pkg.sv @@
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD SPI-mode host sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int BC_W = $clog2(BLOCK_BYTES + 1);

  typedef enum logic [1:0] {
    FN_REQ  = 2'd0,
    FN_RX   = 2'd1,
    FN_DATA = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_R1_POLL  = 2'd0,
    CFG_INIT_RTY = 2'd1,
    CFG_ACMD_RTY = 2'd2,
    CFG_WR_RESP  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] r1_poll;
    logic [15:0] init_rty;
    logic [15:0] acmd_rty;
    logic [15:0] wr_resp;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  op;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_low;
    logic       need_data;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic       status;
  } res_t;

endpackage

@@ hdl/sdspi_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sdspi_cfg_regs
// Limit registers written through the configuration channel.
// ----------------------------------------------------------------------------
module sdspi_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output sdspi_pkg::cfg_t     cfg
);

  sdspi_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.r1_poll  <= 16'd4095;
      cfg_r.init_rty <= 16'd255;
      cfg_r.acmd_rty <= 16'd4095;
      cfg_r.wr_resp  <= 16'd4095;
    end else if (cfg_valid) begin
      case (sdspi_pkg::cfg_idx_t'(cfg_index))
        sdspi_pkg::CFG_R1_POLL:  cfg_r.r1_poll  <= cfg_data;
        sdspi_pkg::CFG_INIT_RTY: cfg_r.init_rty <= cfg_data;
        sdspi_pkg::CFG_ACMD_RTY: cfg_r.acmd_rty <= cfg_data;
        sdspi_pkg::CFG_WR_RESP:  cfg_r.wr_resp  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/sdspi_seq_core.sv @@
// ----------------------------------------------------------------------------
// sdspi_seq_core
// Sequencer state and next-byte decision; one item per enabled cycle.
// ----------------------------------------------------------------------------
module sdspi_seq_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  sdspi_pkg::item_t  item,
  input  sdspi_pkg::cfg_t   cfg,
  output sdspi_pkg::res_t   res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_DUMMY, PH_FRAME, PH_R1, PH_REST, PH_END, PH_RD_TOKEN, PH_RD_DATA,
    PH_RD_CRC, PH_WR_PRE, PH_WR_TOKEN, PH_WR_NEED, PH_WR_DATA, PH_WR_CRC,
    PH_WR_RESP, PH_WR_BUSY, PH_WR_STOP, PH_WR_STOPBUSY
  } phase_t;

  typedef enum logic [3:0] {
    ST_CMD0, ST_CMD8, ST_OCR1, ST_CMD55, ST_ACMD41, ST_OCR2, ST_CMD16, ST_RDCMD,
    ST_RDTAIL, ST_RDSTOP, ST_RDLAST, ST_WRCMD, ST_WREND, ST_FAILEND
  } step_t;

  phase_t phase_r, phase_nxt;
  step_t  step_r, step_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic [15:0] poll_r, poll_nxt, rty_r, rty_nxt, blk_r, blk_nxt;
  logic [sdspi_pkg::BC_W-1:0] bcnt_r, bcnt_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [7:0]  rsp_r [4];
  logic [7:0]  rsp_nxt [4];
  logic        multi_r, multi_nxt, stdcap_r, stdcap_nxt;
  logic [7:0]  r1_r, r1_nxt;

  logic       txv, rdv, done, stat;
  logic [7:0] tx, rd;

  function automatic logic [15:0] eff(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [5:0] cmd_idx(input step_t s, input logic m);
    case (s)
      ST_CMD8:           return 6'd8;
      ST_OCR1, ST_OCR2:  return 6'd58;
      ST_CMD55:          return 6'd55;
      ST_ACMD41:         return 6'd41;
      ST_CMD16:          return 6'd16;
      ST_RDCMD:          return m ? 6'd18 : 6'd17;
      ST_RDSTOP:         return 6'd12;
      ST_WRCMD:          return m ? 6'd25 : 6'd24;
      default:           return 6'd0;
    endcase
  endfunction

  function automatic logic [7:0] fbyte(input logic [3:0] i, input step_t s, input logic m,
                                       input logic [31:0] a);
    case (i)
      4'd0:    return 8'h40 | {2'b00, cmd_idx(s, m)};
      4'd1:    return a[31:24];
      4'd2:    return a[23:16];
      4'd3:    return a[15:8];
      4'd4:    return a[7:0];
      default: return (s == ST_CMD0) ? 8'h95 : ((s == ST_CMD8) ? 8'h87 : 8'h00);
    endcase
  endfunction

  always_comb begin
    logic [7:0] rx;
    logic [15:0] pc;
    phase_nxt = phase_r; step_nxt = step_r; fidx_nxt = fidx_r; poll_nxt = poll_r;
    rty_nxt = rty_r; blk_nxt = blk_r; bcnt_nxt = bcnt_r; arg_nxt = arg_r;
    rsp_nxt = rsp_r; multi_nxt = multi_r; stdcap_nxt = stdcap_r; r1_nxt = r1_r;
    txv = 1'b0; tx = 8'h00; rdv = 1'b0; rd = 8'h00; done = 1'b0; stat = 1'b0;
    rx = item.rx_byte;
    pc = poll_r + 16'd1;

    // start_cmd / send / finish helpers written inline in the case arms below
    case (sdspi_pkg::func_t'(item.func))
      sdspi_pkg::FN_REQ: begin
        if (phase_r == PH_IDLE) begin
          case (sdspi_pkg::op_t'(item.op))
            sdspi_pkg::OP_INIT: begin
              rty_nxt = '0; bcnt_nxt = '0; phase_nxt = PH_DUMMY; txv = 1'b1; tx = 8'hFF;
            end
            sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: begin
              blk_nxt = item.block_count;
              multi_nxt = (item.block_count != 16'd1);
              step_nxt = (item.op == sdspi_pkg::OP_READ) ? ST_RDCMD : ST_WRCMD;
              arg_nxt = item.sector; fidx_nxt = '0; phase_nxt = PH_FRAME; txv = 1'b1;
              tx = fbyte(4'd0, step_nxt, multi_nxt, arg_nxt);
            end
            default: begin
              phase_nxt = PH_IDLE; done = 1'b1; stat = 1'b1;
            end
          endcase
        end
      end
      sdspi_pkg::FN_DATA: begin
        if (phase_r == PH_WR_NEED) begin
          phase_nxt = PH_WR_DATA; txv = 1'b1; tx = item.data_byte;
        end
      end
      sdspi_pkg::FN_RX: begin
        txv = 1'b1; tx = 8'hFF;
        case (phase_r)
          PH_DUMMY: begin
            bcnt_nxt = bcnt_r + 1'b1;
            if (bcnt_nxt >= sdspi_pkg::BC_W'(10)) begin
              rty_nxt = '0; step_nxt = ST_CMD0; arg_nxt = '0; fidx_nxt = '0;
              phase_nxt = PH_FRAME; tx = fbyte(4'd0, ST_CMD0, multi_r, 32'd0);
            end
          end
          PH_FRAME: begin
            fidx_nxt = fidx_r + 4'd1;
            if (fidx_nxt < 4'd6) tx = fbyte(fidx_nxt, step_r, multi_r, arg_r);
            else begin poll_nxt = '0; phase_nxt = PH_R1; end
          end
          PH_R1: begin
            poll_nxt = pc;
            if (rx != 8'hFF || pc >= eff(cfg.r1_poll)) begin
              r1_nxt = rx;
              case (step_r)
                ST_RDCMD: begin
                  if (rx != 8'h00) begin step_nxt = ST_FAILEND; phase_nxt = PH_END; end
                  else if (blk_r != 16'd0) begin poll_nxt = '0; phase_nxt = PH_RD_TOKEN; end
                  else begin step_nxt = ST_RDTAIL; phase_nxt = PH_END; end
                end
                ST_WRCMD: begin
                  if (rx != 8'h00) begin step_nxt = ST_FAILEND; phase_nxt = PH_END; end
                  else if (blk_r != 16'd0) phase_nxt = PH_WR_PRE;
                  else begin phase_nxt = PH_WR_STOP; tx = 8'hFD; end
                end
                ST_CMD8, ST_OCR1, ST_OCR2: begin fidx_nxt = '0; phase_nxt = PH_REST; end
                default: phase_nxt = PH_END;
              endcase
            end
          end
          PH_REST: begin
            rsp_nxt[fidx_r[1:0]] = rx;
            fidx_nxt = fidx_r + 4'd1;
            if (fidx_nxt >= 4'd4) phase_nxt = PH_END;
          end
          PH_END: begin
            logic do_rty, do_start;
            logic [15:0] lim;
            step_t ns, rs;
            logic [31:0] na, ra;
            do_rty = 1'b0; do_start = 1'b0; lim = 16'd1;
            ns = ST_CMD0; rs = ST_CMD0; na = '0; ra = '0;
            txv = 1'b0; tx = 8'h00;
            case (step_r)
              ST_CMD0: if (r1_r == 8'h01) begin rty_nxt = '0; do_start = 1'b1; ns = ST_CMD8;
                na = 32'h01AA; end else begin do_rty = 1'b1; lim = cfg.init_rty; end
              ST_CMD8: if (r1_r == 8'h01 && rsp_r[2][3:0] == 4'h1 && rsp_r[3] == 8'hAA) begin
                rty_nxt = '0; do_start = 1'b1; ns = ST_OCR1; end
                else begin done = 1'b1; stat = 1'b1; end
              ST_OCR1: if (r1_r == 8'h01 && rsp_r[1][4:0] != 5'd0 && rsp_r[2][7]) begin
                rty_nxt = '0; do_start = 1'b1; ns = ST_CMD55; end
                else begin do_rty = 1'b1; lim = cfg.init_rty; rs = ST_OCR1; end
              ST_CMD55: if (r1_r != 8'h01) begin done = 1'b1; stat = 1'b1; end
                else begin do_start = 1'b1; ns = ST_ACMD41; na = 32'h40000000; end
              ST_ACMD41: if (r1_r == 8'h00) begin rty_nxt = '0; do_start = 1'b1; ns = ST_OCR2; end
                else begin do_rty = 1'b1; lim = cfg.acmd_rty; rs = ST_CMD55; end
              ST_OCR2: if (r1_r == 8'h00) begin
                  if (rsp_r[0][6]) begin stdcap_nxt = 1'b0; done = 1'b1; end
                  else begin rty_nxt = '0; do_start = 1'b1; ns = ST_CMD16;
                    na = 32'(sdspi_pkg::BLOCK_BYTES); end
                end else begin do_rty = 1'b1; lim = cfg.init_rty; rs = ST_OCR2; end
              ST_CMD16: if (r1_r == 8'h00) begin stdcap_nxt = 1'b1; done = 1'b1; end
                else begin do_rty = 1'b1; lim = cfg.init_rty; rs = ST_CMD16;
                  ra = 32'(sdspi_pkg::BLOCK_BYTES); end
              ST_RDTAIL: if (multi_r) begin do_start = 1'b1; ns = ST_RDSTOP; end
                else begin done = 1'b1; stat = (blk_r != 16'd0); end
              ST_RDSTOP: begin step_nxt = ST_RDLAST; phase_nxt = PH_END; txv = 1'b1;
                tx = 8'hFF; end
              ST_RDLAST: begin done = 1'b1; stat = (blk_r != 16'd0); end
              ST_WREND: done = 1'b1;
              default: begin done = 1'b1; stat = 1'b1; end
            endcase
            if (do_rty) begin
              rty_nxt = rty_r + 16'd1;
              if (rty_nxt >= eff(lim)) begin done = 1'b1; stat = 1'b1; end
              else begin do_start = 1'b1; ns = rs; na = ra; end
            end
            if (done) phase_nxt = PH_IDLE;
            if (do_start) begin
              step_nxt = ns; arg_nxt = na; fidx_nxt = '0; phase_nxt = PH_FRAME;
              txv = 1'b1; tx = fbyte(4'd0, ns, multi_r, na);
            end
          end
          PH_RD_TOKEN: begin
            poll_nxt = pc;
            if (rx == 8'hFE) begin bcnt_nxt = '0; phase_nxt = PH_RD_DATA; end
            else if (rx == 8'hFF && pc < eff(cfg.r1_poll)) phase_nxt = PH_RD_TOKEN;
            else begin step_nxt = ST_RDTAIL; phase_nxt = PH_END; end
          end
          PH_RD_DATA: begin
            rdv = 1'b1; rd = rx;
            bcnt_nxt = bcnt_r + 1'b1;
            if (bcnt_nxt >= sdspi_pkg::BC_W'(sdspi_pkg::BLOCK_BYTES)) begin
              fidx_nxt = '0; phase_nxt = PH_RD_CRC;
            end
          end
          PH_RD_CRC: begin
            fidx_nxt = fidx_r + 4'd1;
            if (fidx_nxt >= 4'd2) begin
              blk_nxt = blk_r - 16'd1;
              if (blk_nxt != 16'd0) begin poll_nxt = '0; phase_nxt = PH_RD_TOKEN; end
              else begin step_nxt = ST_RDTAIL; phase_nxt = PH_END; end
            end
          end
          PH_WR_PRE: begin phase_nxt = PH_WR_TOKEN; tx = multi_r ? 8'hFC : 8'hFE; end
          PH_WR_TOKEN: begin bcnt_nxt = '0; phase_nxt = PH_WR_NEED; txv = 1'b0; tx = 8'h00; end
          PH_WR_DATA: begin
            bcnt_nxt = bcnt_r + 1'b1;
            if (bcnt_nxt >= sdspi_pkg::BC_W'(sdspi_pkg::BLOCK_BYTES)) begin
              fidx_nxt = '0; phase_nxt = PH_WR_CRC;
            end else begin phase_nxt = PH_WR_NEED; txv = 1'b0; tx = 8'h00; end
          end
          PH_WR_CRC: begin
            fidx_nxt = fidx_r + 4'd1;
            if (fidx_nxt >= 4'd2) begin poll_nxt = '0; phase_nxt = PH_WR_RESP; end
          end
          PH_WR_RESP: begin
            poll_nxt = pc;
            if (rx[4:0] == 5'h05) phase_nxt = PH_WR_BUSY;
            else if (pc >= eff(cfg.wr_resp)) begin step_nxt = ST_FAILEND; phase_nxt = PH_END; end
          end
          PH_WR_BUSY: begin
            if (rx == 8'hFF) begin
              blk_nxt = blk_r - 16'd1;
              if (blk_nxt != 16'd0) phase_nxt = PH_WR_PRE;
              else if (multi_r) begin phase_nxt = PH_WR_STOP; tx = 8'hFD; end
              else begin step_nxt = ST_WREND; phase_nxt = PH_END; end
            end
          end
          PH_WR_STOP: phase_nxt = PH_WR_STOPBUSY;
          PH_WR_STOPBUSY: begin
            if (rx == 8'hFF) begin step_nxt = ST_WREND; phase_nxt = PH_END; end
          end
          default: begin txv = 1'b0; tx = 8'h00; end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; step_r <= ST_CMD0; fidx_r <= '0; poll_r <= '0; rty_r <= '0;
      blk_r <= '0; bcnt_r <= '0; arg_r <= '0; multi_r <= 1'b0; stdcap_r <= 1'b0;
      r1_r <= '0;
      for (int i = 0; i < 4; i++) rsp_r[i] <= '0;
    end else if (en) begin
      phase_r <= phase_nxt; step_r <= step_nxt; fidx_r <= fidx_nxt; poll_r <= poll_nxt;
      rty_r <= rty_nxt; blk_r <= blk_nxt; bcnt_r <= bcnt_nxt; arg_r <= arg_nxt;
      multi_r <= multi_nxt; stdcap_r <= stdcap_nxt; r1_r <= r1_nxt;
      for (int i = 0; i < 4; i++) rsp_r[i] <= rsp_nxt[i];
    end
  end

  always_comb begin
    res.tx_valid   = txv;
    res.tx_byte    = tx;
    res.select_low = (phase_nxt != PH_IDLE) && (phase_nxt != PH_DUMMY) &&
                     (phase_nxt != PH_END);
    res.need_data  = (phase_nxt == PH_WR_NEED);
    res.rd_valid   = rdv;
    res.rd_byte    = rd;
    res.done_res   = done;
    res.status     = stat;
  end

  // capacity flag is held as card state only; no port reports it
  logic unused_stdcap;
  assign unused_stdcap = stdcap_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.done_res) |=> (phase_r == PH_IDLE)) else $error("done without idle");
  a_rd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.rd_valid) |-> (phase_r == PH_RD_DATA)) else $error("read byte out of phase");
  a_need_notx: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.need_data) |-> !res.done_res) else $error("need_data with done");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    res.status |-> res.done_res) else $error("status without done");

endmodule

@@ hdl/sd_spi_host_sequencer_top.sv @@
// One item is one SPI byte exchange: a request, a byte returned from the card, or a
// write payload byte. Each accepted beat yields exactly one result beat, decided
// combinationally by the sequencer core; a new beat is taken every cycle while the output
// register is free or being drained. A beat passes the input register, core, output register.
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer_top
// SD card SPI-mode host sequencer: input register, core, output register.
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_sector,
  input  logic [15:0] in_block_count,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_select_low,
  output logic        out_need_data,
  output logic        out_rd_valid,
  output logic [7:0]  out_rd_byte,
  output logic        out_done_res,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sdspi_pkg::cfg_t  cfg;
  sdspi_pkg::item_t in_r;
  sdspi_pkg::res_t  res, out_r;
  logic             inv_r, outv_r, adv;

  assign cfg_ready = 1'b1;

  sdspi_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  // stage 1 moves into the output register when it is empty or draining
  assign adv      = inv_r && (!outv_r || !out_stall);
  assign in_stall = inv_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (!in_stall) begin
      inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= '{in_func, in_op, in_sector, in_block_count, in_rx_byte, in_data_byte};
    end
  end

  sdspi_seq_core u_core (
    .clk(clk), .rst_n(rst_n), .en(adv), .item(in_r), .cfg(cfg), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (adv) begin
      outv_r <= 1'b1;
    end else if (!out_stall) begin
      outv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= res;
  end

  assign out_valid      = outv_r;
  assign out_tx_valid   = out_r.tx_valid;
  assign out_tx_byte    = out_r.tx_byte;
  assign out_select_low = out_r.select_low;
  assign out_need_data  = out_r.need_data;
  assign out_rd_valid   = out_r.rd_valid;
  assign out_rd_byte    = out_r.rd_byte;
  assign out_done_res   = out_r.done_res;
  assign out_status     = out_r.status;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SD SPI-mode host sequencer. A small card
// model answers every exchange so init, read and write sequences run deep,
// mixed with noise beats. Each accepted beat is stepped through a local
// sequencer model and every result beat is compared in order. Random gaps
// and stalls on both channels; limit registers swept between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 400;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] CMD_START = 8'h40;
  localparam logic [7:0] CRC_CMD0  = 8'h95;
  localparam logic [7:0] CRC_CMD8  = 8'h87;
  localparam logic [7:0] TOK_SINGLE = 8'hFE;
  localparam logic [7:0] TOK_MULTI  = 8'hFC;
  localparam logic [7:0] TOK_STOP   = 8'hFD;
  localparam logic [7:0] R1_IDLE = 8'h01;
  localparam logic [7:0] R1_READY = 8'h00;
  localparam logic [7:0] R1_ERR = 8'h04;
  localparam logic [4:0] DRESP_OK = 5'h05;

  typedef enum logic [4:0] {
    P_IDLE, P_DUMMY, P_FRAME, P_R1, P_REST, P_END, P_RD_TOKEN, P_RD_DATA, P_RD_CRC,
    P_WR_PRE, P_WR_TOKEN, P_WR_NEED, P_WR_DATA, P_WR_CRC, P_WR_RESP, P_WR_BUSY,
    P_WR_STOP, P_WR_STOPBUSY
  } seq_phase_t;

  typedef enum logic [3:0] {
    C_GO_IDLE, C_IF_COND, C_OCR_FIRST, C_APP, C_OP_COND, C_OCR_LAST, C_BLOCKLEN,
    C_READ, C_READ_TAIL, C_READ_STOP, C_READ_LAST, C_WRITE, C_WRITE_END, C_FAIL_END
  } cmd_step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = sdspi_pkg::FN_NONE;
  logic [1:0]  in_op = sdspi_pkg::OP_INIT;
  logic [31:0] in_sector = '0;
  logic [15:0] in_block_count = '0;
  logic [7:0]  in_rx_byte = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_tx_valid, out_select_low, out_need_data, out_rd_valid;
  logic        out_done_res, out_status;
  logic [7:0]  out_tx_byte, out_rd_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = sdspi_pkg::CFG_R1_POLL;
  logic [15:0] cfg_data = '0;

  sd_spi_host_sequencer_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer model state
  sdspi_pkg::cfg_t lim;
  seq_phase_t  ph;
  cmd_step_t   step;
  int          frame_idx, poll_cnt, retry_cnt, byte_cnt;
  logic [15:0] blocks_left;
  logic [31:0] cur_arg;
  logic [7:0]  resp_bytes [4];
  logic        multi, std_cap, abort_xfer;
  logic [7:0]  last_r1;
  sdspi_pkg::res_t pr;

  sdspi_pkg::res_t exp_q[$];
  int   fails = 0, errs = 0, checked = 0, items = 0, requests = 0, quiet = 0;

  function automatic int eff(logic [15:0] v);
    return (v == 16'd0) ? 1 : int'(v);
  endfunction

  function automatic void send(seq_phase_t p, logic [7:0] b);
    ph = p; pr.tx_valid = 1'b1; pr.tx_byte = b;
  endfunction

  function automatic void finish_req(logic fail);
    ph = P_IDLE; pr.done_res = 1'b1; pr.status = fail;
  endfunction

  function automatic logic [7:0] frame_byte(int i);
    logic [7:0] idx;
    case (step)
      C_IF_COND: idx = 8'd8;
      C_OCR_FIRST, C_OCR_LAST: idx = 8'd58;
      C_APP: idx = 8'd55;
      C_OP_COND: idx = 8'd41;
      C_BLOCKLEN: idx = 8'd16;
      C_READ: idx = multi ? 8'd18 : 8'd17;
      C_READ_STOP: idx = 8'd12;
      C_WRITE: idx = multi ? 8'd25 : 8'd24;
      default: idx = 8'd0;
    endcase
    case (i)
      0: return CMD_START | idx;
      1: return cur_arg[31:24];
      2: return cur_arg[23:16];
      3: return cur_arg[15:8];
      4: return cur_arg[7:0];
      default: return (step == C_GO_IDLE) ? CRC_CMD0 : (step == C_IF_COND) ? CRC_CMD8 : 8'h00;
    endcase
  endfunction

  function automatic void start_cmd(cmd_step_t s, logic [31:0] arg);
    step = s; cur_arg = arg; frame_idx = 0;
    send(P_FRAME, frame_byte(0));
  endfunction

  function automatic void end_then(cmd_step_t s);
    step = s; send(P_END, IDLE_BYTE);
  endfunction

  function automatic void retry(logic [15:0] limit, cmd_step_t s, logic [31:0] arg);
    retry_cnt++;
    if (retry_cnt >= eff(limit)) finish_req(1'b1);
    else start_cmd(s, arg);
  endfunction

  function automatic void after_r1();
    case (step)
      C_READ: begin
        if (last_r1 != 8'h00) end_then(C_FAIL_END);
        else if (blocks_left != 16'd0) begin poll_cnt = 0; send(P_RD_TOKEN, IDLE_BYTE); end
        else end_then(C_READ_TAIL);
      end
      C_WRITE: begin
        if (last_r1 != 8'h00) end_then(C_FAIL_END);
        else if (blocks_left != 16'd0) send(P_WR_PRE, IDLE_BYTE);
        else send(P_WR_STOP, TOK_STOP);
      end
      C_IF_COND, C_OCR_FIRST, C_OCR_LAST: begin
        frame_idx = 0; send(P_REST, IDLE_BYTE);
      end
      default: send(P_END, IDLE_BYTE);
    endcase
  endfunction

  function automatic void after_end();
    case (step)
      C_GO_IDLE:
        if (last_r1 == R1_IDLE) begin retry_cnt = 0; start_cmd(C_IF_COND, 32'h01AA); end
        else retry(lim.init_rty, C_GO_IDLE, 32'd0);
      C_IF_COND:
        if (last_r1 == R1_IDLE && resp_bytes[2][3:0] == 4'h1 && resp_bytes[3] == 8'hAA) begin
          retry_cnt = 0; start_cmd(C_OCR_FIRST, 32'd0);
        end else finish_req(1'b1);
      C_OCR_FIRST:
        if (last_r1 == R1_IDLE && resp_bytes[1][4:0] != 5'd0 && resp_bytes[2][7]) begin
          retry_cnt = 0; start_cmd(C_APP, 32'd0);
        end else retry(lim.init_rty, C_OCR_FIRST, 32'd0);
      C_APP:
        if (last_r1 != R1_IDLE) finish_req(1'b1);
        else start_cmd(C_OP_COND, 32'h4000_0000);
      C_OP_COND:
        if (last_r1 == R1_READY) begin retry_cnt = 0; start_cmd(C_OCR_LAST, 32'd0); end
        else retry(lim.acmd_rty, C_APP, 32'd0);
      C_OCR_LAST:
        if (last_r1 == R1_READY) begin
          if (resp_bytes[0][6]) begin std_cap = 1'b0; finish_req(1'b0); end
          else begin
            retry_cnt = 0; start_cmd(C_BLOCKLEN, 32'(sdspi_pkg::BLOCK_BYTES));
          end
        end else retry(lim.init_rty, C_OCR_LAST, 32'd0);
      C_BLOCKLEN:
        if (last_r1 == R1_READY) begin std_cap = 1'b1; finish_req(1'b0); end
        else retry(lim.init_rty, C_BLOCKLEN, 32'(sdspi_pkg::BLOCK_BYTES));
      C_READ_TAIL:
        if (multi) start_cmd(C_READ_STOP, 32'd0);
        else finish_req(blocks_left != 16'd0);
      C_READ_STOP: end_then(C_READ_LAST);
      C_READ_LAST: finish_req(blocks_left != 16'd0);
      C_WRITE_END: finish_req(1'b0);
      default: finish_req(1'b1);
    endcase
  endfunction

  function automatic void on_card_byte(logic [7:0] rx);
    case (ph)
      P_DUMMY: begin
        byte_cnt++;
        if (byte_cnt < 10) send(P_DUMMY, IDLE_BYTE);
        else begin retry_cnt = 0; start_cmd(C_GO_IDLE, 32'd0); end
      end
      P_FRAME: begin
        frame_idx++;
        if (frame_idx < 6) send(P_FRAME, frame_byte(frame_idx));
        else begin poll_cnt = 0; send(P_R1, IDLE_BYTE); end
      end
      P_R1: begin
        poll_cnt++;
        if (rx != IDLE_BYTE || poll_cnt >= eff(lim.r1_poll)) begin last_r1 = rx; after_r1(); end
        else send(P_R1, IDLE_BYTE);
      end
      P_REST: begin
        resp_bytes[frame_idx & 3] = rx;
        frame_idx++;
        send(frame_idx < 4 ? P_REST : P_END, IDLE_BYTE);
      end
      P_END: after_end();
      P_RD_TOKEN: begin
        poll_cnt++;
        if (rx == TOK_SINGLE) begin byte_cnt = 0; send(P_RD_DATA, IDLE_BYTE); end
        else if (rx == IDLE_BYTE && poll_cnt < eff(lim.r1_poll)) send(P_RD_TOKEN, IDLE_BYTE);
        else end_then(C_READ_TAIL);
      end
      P_RD_DATA: begin
        pr.rd_valid = 1'b1; pr.rd_byte = rx;
        byte_cnt++;
        if (byte_cnt < sdspi_pkg::BLOCK_BYTES) send(P_RD_DATA, IDLE_BYTE);
        else begin frame_idx = 0; send(P_RD_CRC, IDLE_BYTE); end
      end
      P_RD_CRC: begin
        frame_idx++;
        if (frame_idx < 2) send(P_RD_CRC, IDLE_BYTE);
        else begin
          blocks_left = blocks_left - 16'd1;
          if (blocks_left != 16'd0) begin poll_cnt = 0; send(P_RD_TOKEN, IDLE_BYTE); end
          else end_then(C_READ_TAIL);
        end
      end
      P_WR_PRE: send(P_WR_TOKEN, multi ? TOK_MULTI : TOK_SINGLE);
      P_WR_TOKEN: begin byte_cnt = 0; ph = P_WR_NEED; end
      P_WR_DATA: begin
        byte_cnt++;
        if (byte_cnt < sdspi_pkg::BLOCK_BYTES) ph = P_WR_NEED;
        else begin frame_idx = 0; send(P_WR_CRC, IDLE_BYTE); end
      end
      P_WR_CRC: begin
        frame_idx++;
        if (frame_idx < 2) send(P_WR_CRC, IDLE_BYTE);
        else begin poll_cnt = 0; send(P_WR_RESP, IDLE_BYTE); end
      end
      P_WR_RESP: begin
        poll_cnt++;
        if (rx[4:0] == DRESP_OK) send(P_WR_BUSY, IDLE_BYTE);
        else if (poll_cnt >= eff(lim.wr_resp)) end_then(C_FAIL_END);
        else send(P_WR_RESP, IDLE_BYTE);
      end
      P_WR_BUSY: begin
        if (rx != IDLE_BYTE) send(P_WR_BUSY, IDLE_BYTE);
        else begin
          blocks_left = blocks_left - 16'd1;
          if (blocks_left != 16'd0) send(P_WR_PRE, IDLE_BYTE);
          else if (multi) send(P_WR_STOP, TOK_STOP);
          else end_then(C_WRITE_END);
        end
      end
      P_WR_STOP: send(P_WR_STOPBUSY, IDLE_BYTE);
      P_WR_STOPBUSY:
        if (rx == IDLE_BYTE) end_then(C_WRITE_END);
        else send(P_WR_STOPBUSY, IDLE_BYTE);
      default: ;
    endcase
  endfunction

  function automatic sdspi_pkg::res_t seq_step(sdspi_pkg::item_t it);
    pr = '0;
    case (it.func)
      sdspi_pkg::FN_REQ:
        if (ph == P_IDLE) begin
          case (it.op)
            sdspi_pkg::OP_INIT: begin
              retry_cnt = 0; byte_cnt = 0; send(P_DUMMY, IDLE_BYTE);
            end
            sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: begin
              blocks_left = it.block_count;
              multi = (it.block_count != 16'd1);
              start_cmd(it.op == sdspi_pkg::OP_READ ? C_READ : C_WRITE, it.sector);
            end
            default: finish_req(1'b1);
          endcase
        end
      sdspi_pkg::FN_RX: if (ph != P_IDLE && ph != P_WR_NEED) on_card_byte(it.rx_byte);
      sdspi_pkg::FN_DATA: if (ph == P_WR_NEED) send(P_WR_DATA, it.data_byte);
      default: ;
    endcase
    pr.select_low = !(ph inside {P_IDLE, P_DUMMY, P_END});
    pr.need_data = (ph == P_WR_NEED);
    return pr;
  endfunction

  // card side: answers that keep sequences well formed most of the time
  function automatic logic [7:0] card_answer();
    logic [7:0] r;
    r = 8'($urandom);
    case (ph)
      P_R1: begin
        if ($urandom_range(0, 3) == 0) return IDLE_BYTE;
        case (step)
          C_READ, C_WRITE: return abort_xfer ? R1_ERR : R1_READY;
          C_OP_COND: return ($urandom_range(0, 2) == 0) ? R1_READY : R1_IDLE;
          C_OCR_LAST, C_BLOCKLEN: return ($urandom_range(0, 7) == 0) ? R1_IDLE : R1_READY;
          C_READ_STOP: return r;
          default: return ($urandom_range(0, 9) == 0) ? r : R1_IDLE;
        endcase
      end
      P_REST: begin
        if ($urandom_range(0, 9) == 0) return r;
        if (step == C_IF_COND && frame_idx == 2) return {r[7:4], 4'h1};
        if (step == C_IF_COND && frame_idx == 3) return 8'hAA;
        if (step == C_OCR_FIRST && frame_idx == 1) return r | 8'h01;
        if (step == C_OCR_FIRST && frame_idx == 2) return r | 8'h80;
        return r;
      end
      P_RD_TOKEN:
        if ($urandom_range(0, 2) == 0) return IDLE_BYTE;
        else return ($urandom_range(0, 9) == 0) ? r : TOK_SINGLE;
      P_WR_RESP:
        if ($urandom_range(0, 2) == 0) return IDLE_BYTE;
        else return ($urandom_range(0, 9) == 0) ? r : {r[7:5], DRESP_OK};
      P_WR_BUSY, P_WR_STOPBUSY: return $urandom_range(0, 1) ? IDLE_BYTE : 8'h00;
      default: return r;
    endcase
  endfunction

  function automatic sdspi_pkg::item_t next_item();
    sdspi_pkg::item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(sdspi_pkg::item_t)-1:0];
    if ($urandom_range(0, 99) < 6) begin
      // a noise request with a long count must not stream for ages
      if (ph == P_IDLE) abort_xfer = (it.block_count > 16'd2);
      return it;
    end
    case (ph)
      P_IDLE: begin
        it.func = sdspi_pkg::FN_REQ;
        case ($urandom_range(0, 19))
          0: it.op = sdspi_pkg::OP_BAD;
          1, 2, 3, 4, 5, 6: it.op = sdspi_pkg::OP_INIT;
          7, 8, 9, 10, 11, 12: it.op = sdspi_pkg::OP_READ;
          default: it.op = sdspi_pkg::OP_WRITE;
        endcase
        case ($urandom_range(0, 9))
          0: it.block_count = 16'd0;
          1: it.block_count = 16'd2;
          2: it.block_count = 16'($urandom_range(3, 16'hFFFF));
          default: it.block_count = 16'd1;
        endcase
        abort_xfer = (it.block_count > 16'd2) || ($urandom_range(0, 3) == 0);
      end
      P_WR_NEED: it.func = sdspi_pkg::FN_DATA;
      default: begin it.func = sdspi_pkg::FN_RX; it.rx_byte = card_answer(); end
    endcase
    return it;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic drive(sdspi_pkg::item_t it, bit typed, sdspi_pkg::res_t want);
    sdspi_pkg::res_t p;
    int n;
    in_valid <= 1'b1;
    in_func <= it.func; in_op <= it.op; in_sector <= it.sector;
    in_block_count <= it.block_count; in_rx_byte <= it.rx_byte; in_data_byte <= it.data_byte;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    p = seq_step(it);
    exp_q.push_back(typed ? want : p);
    items++;
    if (it.func == sdspi_pkg::FN_REQ) requests++;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(sdspi_pkg::cfg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      sdspi_pkg::CFG_R1_POLL: lim.r1_poll = v;
      sdspi_pkg::CFG_INIT_RTY: lim.init_rty = v;
      sdspi_pkg::CFG_ACMD_RTY: lim.acmd_rty = v;
      default: lim.wr_resp = v;
    endcase
  endtask

  task automatic settle();
    while (ph != P_IDLE) drive(next_item(), 1'b0, '0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic sdspi_pkg::item_t mk(sdspi_pkg::func_t f, sdspi_pkg::op_t o,
                                          logic [31:0] s, logic [15:0] bc,
                                          logic [7:0] rx, logic [7:0] d);
    sdspi_pkg::item_t it;
    it.func = f; it.op = o; it.sector = s; it.block_count = bc;
    it.rx_byte = rx; it.data_byte = d;
    return it;
  endfunction

  // result beats, checked in order
  always @(posedge clk) begin
    sdspi_pkg::res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_tx_valid, out_tx_byte, out_select_low, out_need_data,
             out_rd_valid, out_rd_byte, out_done_res, out_status};
      if (exp_q.size() == 0) begin
        fails++;
        if (errs++ < 10) $display("unexpected result beat %p", got);
      end else begin
        want = exp_q.pop_front();
        checked++;
        if (got !== want) begin
          fails++;
          if (errs++ < 10)
            $display("mismatch beat %0d: exp tx=%0b/%h sel=%0b need=%0b rd=%0b/%h done=%0b/%0b",
                     checked, want.tx_valid, want.tx_byte, want.select_low, want.need_data,
                     want.rd_valid, want.rd_byte, want.done_res, want.status);
          if (errs <= 10)
            $display("                 got tx=%0b/%h sel=%0b need=%0b rd=%0b/%h done=%0b/%0b",
                     got.tx_valid, got.tx_byte, got.select_low, got.need_data,
                     got.rd_valid, got.rd_byte, got.done_res, got.status);
        end
      end
    end
  end

  int stall_hold = 0;
  always @(posedge clk) begin
    int r;
    if (!rst_n) out_stall <= 1'b0;
    else if (stall_hold > 0) stall_hold <= stall_hold - 1;
    else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin out_stall <= 1'b0; stall_hold <= $urandom_range(0, 12); end
      else if (r < 96) begin out_stall <= 1'b1; stall_hold <= $urandom_range(0, 2); end
      else begin out_stall <= 1'b1; stall_hold <= $urandom_range(10, 40); end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("FAIL sd_spi_host_sequencer_top");
      $finish;
    end
  end

  typedef struct {
    sdspi_pkg::item_t it;
    bit               typed;
    sdspi_pkg::res_t  want;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    sdspi_pkg::cfg_t sets[5];
    lim = '{r1_poll: 16'd4095, init_rty: 16'd255, acmd_rty: 16'd4095, wr_resp: 16'd4095};
    ph = P_IDLE; step = C_GO_IDLE; frame_idx = 0; poll_cnt = 0; retry_cnt = 0; byte_cnt = 0;
    blocks_left = 0; cur_arg = 0; resp_bytes = '{default: 8'h00};
    multi = 0; std_cap = 0; last_r1 = 0; abort_xfer = 0;

    rows.push_back('{mk(sdspi_pkg::FN_REQ, sdspi_pkg::OP_BAD, 0, 0, 0, 0), 1,
                     '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1}});
    rows.push_back('{mk(sdspi_pkg::FN_NONE, sdspi_pkg::OP_BAD, 32'hFFFF_FFFF, 16'hFFFF,
                        8'hFF, 8'hFF), 1, '0});
    rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, TOK_SINGLE, 0), 1, '0});
    rows.push_back('{mk(sdspi_pkg::FN_DATA, sdspi_pkg::OP_READ, 0, 16'hFFFF, 0, 8'hFF), 1, '0});
    rows.push_back('{mk(sdspi_pkg::FN_REQ, sdspi_pkg::OP_READ, 32'hFFFF_FFFF, 1, 0, 0), 1,
                     '{1'b1, 8'h51, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}});
    repeat (6)
      rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, IDLE_BYTE, 0), 0, '0});
    rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, R1_ERR, 0), 0, '0});
    rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, 8'h00, 0), 1,
                     '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1}});
    rows.push_back('{mk(sdspi_pkg::FN_REQ, sdspi_pkg::OP_WRITE, 0, 0, 0, 0), 1,
                     '{1'b1, 8'h59, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}});
    repeat (6)
      rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, IDLE_BYTE, 0), 0, '0});
    rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, R1_READY, 0), 0, '0});
    rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, IDLE_BYTE, 0), 0, '0});
    rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, 8'h00, 0), 0, '0});
    rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, IDLE_BYTE, 0), 0, '0});
    rows.push_back('{mk(sdspi_pkg::FN_RX, sdspi_pkg::OP_INIT, 0, 0, 8'hA5, 0), 1,
                     '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0}});

    sets[0] = '{16'd4095, 16'd255, 16'd4095, 16'd4095};
    sets[1] = '{16'd1, 16'd1, 16'd1, 16'd1};
    sets[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    sets[3] = '{16'd2, 16'd3, 16'd2, 16'd5};
    sets[4] = '{16'($urandom_range(1, 64)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 64)), 16'($urandom_range(1, 64))};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) drive(rows[i].it, rows[i].typed, rows[i].want);
    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(sdspi_pkg::CFG_R1_POLL, sets[p].r1_poll);
      write_reg(sdspi_pkg::CFG_INIT_RTY, sets[p].init_rty);
      write_reg(sdspi_pkg::CFG_ACMD_RTY, sets[p].acmd_rty);
      write_reg(sdspi_pkg::CFG_WR_RESP, sets[p].wr_resp);
      cfg_valid <= 1'b0;
      repeat (PHASE_ITEMS) drive(next_item(), 1'b0, '0);
    end
    settle();

    $display("covered %0d beats (%0d requests) over 5 limit settings, %0d results checked",
             items, requests, checked);
    if (fails == 0) $display("PASS sd_spi_host_sequencer_top");
    else begin
      $display("%0d mismatching result beats", fails);
      $display("FAIL sd_spi_host_sequencer_top");
    end
    $finish;
  end

endmodule

@@ sd_spi_host_sequencer_top.f @@
hdl/sdspi_pkg.sv
hdl/sdspi_cfg_regs.sv
hdl/sdspi_seq_core.sv
hdl/sd_spi_host_sequencer_top.sv
bench/tb_top.sv
